FILE: rtl/core/dfhi_pkg.sv
// shared types, constants and code tables for the fixed-huffman inflater
// used by dfhi_window and deflate_fixed_huffman_inflater
package dfhi_pkg;

  localparam int WINDOW_BYTES_DEF       = 32768;
  localparam int MAX_BYTES_PER_ITEM_DEF = 32;
  localparam int BIT_BUFFER_BITS_DEF    = 32;

  // configuration register indexes and error codes
  localparam logic REG_SKIP_FIRST_BITS = 1'b0;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_LENGTH = 2'd1,
    ERR_BAD_DIST   = 2'd2,
    ERR_REFUSED    = 2'd3
  } err_t;

  typedef enum logic [0:0] {
    OP_DATA     = 1'b0,
    OP_CONTINUE = 1'b1
  } op_t;

  // decode phase kept between items
  typedef enum logic [2:0] {
    PH_SYMBOL     = 3'd0,
    PH_LEN_EXTRA  = 3'd1,
    PH_DIST_CODE  = 3'd2,
    PH_DIST_EXTRA = 3'd3,
    PH_COPY       = 3'd4
  } phase_t;

  // item sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_REDUCE = 3'd2,
    ST_COPY   = 3'd3,
    ST_EMIT   = 3'd4
  } state_t;

  // length base for length symbols 257..285, indexed by symbol - 257
  function automatic logic [8:0] len_base(input logic [4:0] idx);
    logic [8:0] v;
    unique case (idx)
      5'd0: v = 9'd3;     5'd1: v = 9'd4;     5'd2: v = 9'd5;     5'd3: v = 9'd6;
      5'd4: v = 9'd7;     5'd5: v = 9'd8;     5'd6: v = 9'd9;     5'd7: v = 9'd10;
      5'd8: v = 9'd11;    5'd9: v = 9'd13;    5'd10: v = 9'd15;   5'd11: v = 9'd17;
      5'd12: v = 9'd19;   5'd13: v = 9'd23;   5'd14: v = 9'd27;   5'd15: v = 9'd31;
      5'd16: v = 9'd35;   5'd17: v = 9'd43;   5'd18: v = 9'd51;   5'd19: v = 9'd59;
      5'd20: v = 9'd67;   5'd21: v = 9'd83;   5'd22: v = 9'd99;   5'd23: v = 9'd115;
      5'd24: v = 9'd131;  5'd25: v = 9'd163;  5'd26: v = 9'd195;  5'd27: v = 9'd227;
      default: v = 9'd258;
    endcase
    return v;
  endfunction

  // distance base for distance codes 0..29
  function automatic logic [15:0] dist_base(input logic [4:0] dc);
    logic [15:0] v;
    unique case (dc)
      5'd0: v = 16'd1;      5'd1: v = 16'd2;      5'd2: v = 16'd3;      5'd3: v = 16'd4;
      5'd4: v = 16'd5;      5'd5: v = 16'd7;      5'd6: v = 16'd9;      5'd7: v = 16'd13;
      5'd8: v = 16'd17;     5'd9: v = 16'd25;     5'd10: v = 16'd33;    5'd11: v = 16'd49;
      5'd12: v = 16'd65;    5'd13: v = 16'd97;    5'd14: v = 16'd129;   5'd15: v = 16'd193;
      5'd16: v = 16'd257;   5'd17: v = 16'd385;   5'd18: v = 16'd513;   5'd19: v = 16'd769;
      5'd20: v = 16'd1025;  5'd21: v = 16'd1537;  5'd22: v = 16'd2049;  5'd23: v = 16'd3073;
      5'd24: v = 16'd4097;  5'd25: v = 16'd6145;  5'd26: v = 16'd8193;  5'd27: v = 16'd12289;
      5'd28: v = 16'd16385;
      default: v = 16'd24577;
    endcase
    return v;
  endfunction

  // first stream bit lands in the msb of the code
  function automatic logic [8:0] code_rev9(input logic [8:0] bits);
    logic [8:0] v;
    for (int i = 0; i < 9; i++) begin
      v[8-i] = bits[i];
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/dfhi_window.sv
// history window: one write port, one read port with registered data
// depends on dfhi_pkg for the default depth
module dfhi_window #(
  parameter int WINDOW_BYTES = dfhi_pkg::WINDOW_BYTES_DEF,
  localparam int AW = $clog2(WINDOW_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [WINDOW_BYTES];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/deflate_fixed_huffman_inflater.sv
// fixed-huffman deflate block decoder, bytes in lsb first, bytes out one per beat
// takes a byte, then decodes one step at a time (distance extra bits then reduce),
// each copied byte read from the window ram then written, stop found, beats emitted
// one item at a time; no new input is taken until the last beat of the item is taken
// a far distance on a small window is cut by the window length in reduce until it fits
// reset (rst_n low, synchronous) clears decoder state; the window holds no valid bits
// depends on dfhi_pkg and dfhi_window
module deflate_fixed_huffman_inflater #(
  parameter int WINDOW_BYTES       = dfhi_pkg::WINDOW_BYTES_DEF,
  parameter int MAX_BYTES_PER_ITEM = dfhi_pkg::MAX_BYTES_PER_ITEM_DEF,
  parameter int BIT_BUFFER_BITS    = dfhi_pkg::BIT_BUFFER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic        out_end_of_block,
  output logic        out_copy_pending,
  output logic [1:0]  out_error_code,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW    = $clog2(WINDOW_BYTES);
  localparam int LIMIT = (MAX_BYTES_PER_ITEM > 32) ? 32 : MAX_BYTES_PER_ITEM;
  localparam int CW    = $clog2(LIMIT + 1);
  localparam int OBW   = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int BB    = BIT_BUFFER_BITS;
  localparam int HW    = $clog2(BB + 1);

  // registers
  dfhi_pkg::state_t state_r, state_nxt;
  dfhi_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    skip_r;
  logic [BB-1:0] buf_r, buf_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [8:0]    plen_r, plen_nxt;
  logic [4:0]    pdc_r, pdc_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic          done_r, done_nxt;
  logic          skip_pend_r, skip_pend_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          full_r, full_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [7:0]    obuf [LIMIT];

  // window ram
  logic          win_we;
  logic [AW-1:0] win_raddr;
  logic [7:0]    win_wdata, win_rdata;

  dfhi_window #(.WINDOW_BYTES(WINDOW_BYTES)) u_window (
    .clk     (clk),
    .wr_en   (win_we),
    .wr_addr (wp_r),
    .wr_data (win_wdata),
    .rd_addr (win_raddr),
    .rd_data (win_rdata)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == dfhi_pkg::REG_SKIP_FIRST_BITS) ? {29'd0, skip_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 3'd3;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == dfhi_pkg::REG_SKIP_FIRST_BITS) begin
      skip_r <= cfg_pwdata[2:0];
    end
  end

  // handshakes
  logic in_acc, out_acc, emit_last;
  assign in_ready  = (state_r == dfhi_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign emit_last = (count_r == '0) ? 1'b1 : (k_r == count_r - CW'(1));

  // code peek and symbol classification
  logic [8:0] c9;
  logic [6:0] c7;
  logic [7:0] c8;
  logic [4:0] c5;
  logic       sym_ok;
  logic [8:0] sym;
  logic [3:0] sym_n;
  assign c9 = dfhi_pkg::code_rev9(buf_r[8:0]);
  assign c7 = c9[8:2];
  assign c8 = c9[8:1];
  assign c5 = c9[8:4];

  always_comb begin
    priority if (c7 <= 7'h17) begin
      sym_ok = held_r >= HW'(7);
      sym    = 9'd256 + {2'd0, c7};
      sym_n  = 4'd7;
    end else if (c8 <= 8'hBF) begin
      sym_ok = held_r >= HW'(8);
      sym    = {1'b0, c8} - 9'h030;
      sym_n  = 4'd8;
    end else if (c8 <= 8'hC7) begin
      sym_ok = held_r >= HW'(8);
      sym    = 9'd280 + {1'b0, c8 - 8'hC0};
      sym_n  = 4'd8;
    end else begin
      sym_ok = held_r >= HW'(9);
      sym    = 9'd144 + (c9 - 9'h190);
      sym_n  = 4'd9;
    end
  end

  // extra bit counts
  logic [4:0] le_idx, de_code, de_m2;
  logic [3:0] le_n, de_n;
  assign le_idx  = plen_r[4:0];
  assign le_n    = 4'((le_idx - 5'd4) >> 2);
  assign de_code = pdc_r;
  assign de_m2   = de_code - 5'd2;
  assign de_n    = (de_code < 5'd2) ? 4'd0 : 4'(de_m2 >> 1);

  logic [BB-1:0] ext_mask_le, ext_mask_de;
  assign ext_mask_le = (BB'(1) << le_n) - BB'(1);
  assign ext_mask_de = (BB'(1) << de_n) - BB'(1);

  // copy source address
  logic [AW:0] src_wide;
  logic [AW-1:0] src;
  always_comb begin
    if ({1'b0, wp_r} >= dist_r[AW:0]) begin
      src_wide = {1'b0, wp_r} - dist_r[AW:0];
    end else begin
      src_wide = {1'b0, wp_r} + (AW+1)'(WINDOW_BYTES) - dist_r[AW:0];
    end
  end
  assign src = src_wide[AW-1:0];
  assign win_raddr = src;

  // appended byte with header skip
  logic [BB-1:0] merged, skipped;
  logic          refuse;
  assign refuse  = held_r > HW'(BB - 8);
  assign merged  = buf_r | (BB'(in_data_byte) << held_r);
  assign skipped = merged >> skip_r;

  logic [AW-1:0] wp_inc;
  assign wp_inc = (wp_r == AW'(WINDOW_BYTES - 1)) ? '0 : wp_r + AW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfhi_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = dfhi_pkg::ST_DECODE;
      end
      dfhi_pkg::ST_DECODE: begin
        if (done_r || count_r >= CW'(LIMIT)) begin
          state_nxt = dfhi_pkg::ST_EMIT;
        end else begin
          unique case (phase_r)
            dfhi_pkg::PH_SYMBOL:     if (!sym_ok) state_nxt = dfhi_pkg::ST_EMIT;
            dfhi_pkg::PH_LEN_EXTRA:  if (held_r < HW'(le_n)) state_nxt = dfhi_pkg::ST_EMIT;
            dfhi_pkg::PH_DIST_CODE:  if (held_r < HW'(5)) state_nxt = dfhi_pkg::ST_EMIT;
            dfhi_pkg::PH_DIST_EXTRA: begin
              if (held_r < HW'(de_n)) state_nxt = dfhi_pkg::ST_EMIT;
              else state_nxt = dfhi_pkg::ST_REDUCE;
            end
            dfhi_pkg::PH_COPY:       state_nxt = dfhi_pkg::ST_COPY;
            default:                 state_nxt = dfhi_pkg::ST_DECODE;
          endcase
        end
      end
      dfhi_pkg::ST_REDUCE: begin
        if (dist_r < 16'(WINDOW_BYTES)) state_nxt = dfhi_pkg::ST_DECODE;
      end
      dfhi_pkg::ST_COPY: state_nxt = dfhi_pkg::ST_DECODE;
      dfhi_pkg::ST_EMIT: begin
        if (out_acc && emit_last) state_nxt = dfhi_pkg::ST_IDLE;
      end
      default: state_nxt = dfhi_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  logic          obuf_we;
  logic [7:0]    obuf_wdata;
  always_comb begin
    phase_nxt     = phase_r;
    buf_nxt       = buf_r;
    held_nxt      = held_r;
    wp_nxt        = wp_r;
    plen_nxt      = plen_r;
    pdc_nxt       = pdc_r;
    dist_nxt      = dist_r;
    done_nxt      = done_r;
    skip_pend_nxt = skip_pend_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    full_nxt      = full_r;
    err_nxt       = err_r;
    win_we        = 1'b0;
    win_wdata     = win_rdata;
    obuf_we       = 1'b0;
    obuf_wdata    = win_rdata;
    unique case (state_r)
      dfhi_pkg::ST_IDLE: begin
        if (in_acc) begin
          count_nxt = '0;
          k_nxt     = '0;
          full_nxt  = 1'b0;
          err_nxt   = dfhi_pkg::ERR_NONE;
          if (in_operation == dfhi_pkg::OP_DATA && !done_r) begin
            if (refuse) begin
              err_nxt = dfhi_pkg::ERR_REFUSED;
            end else if (skip_pend_r) begin
              buf_nxt       = skipped;
              held_nxt      = held_r + HW'(8) - HW'(skip_r);
              skip_pend_nxt = 1'b0;
            end else begin
              buf_nxt  = merged;
              held_nxt = held_r + HW'(8);
            end
          end
        end
      end
      dfhi_pkg::ST_DECODE: begin
        if (done_r) begin
          full_nxt = full_r;
        end else if (count_r >= CW'(LIMIT)) begin
          full_nxt = 1'b1;
        end else begin
          unique case (phase_r)
            dfhi_pkg::PH_SYMBOL: begin
              if (sym_ok) begin
                buf_nxt  = buf_r >> sym_n;
                held_nxt = held_r - HW'(sym_n);
                if (sym < 9'd256) begin
                  win_we     = 1'b1;
                  win_wdata  = sym[7:0];
                  obuf_we    = 1'b1;
                  obuf_wdata = sym[7:0];
                  count_nxt  = count_r + CW'(1);
                  wp_nxt     = wp_inc;
                end else if (sym == 9'd256) begin
                  done_nxt = 1'b1;
                end else if (sym <= 9'd264) begin
                  plen_nxt  = sym - 9'd254;
                  phase_nxt = dfhi_pkg::PH_DIST_CODE;
                end else if (sym <= 9'd284) begin
                  plen_nxt  = sym - 9'd257;
                  phase_nxt = dfhi_pkg::PH_LEN_EXTRA;
                end else if (sym == 9'd285) begin
                  plen_nxt  = 9'd258;
                  phase_nxt = dfhi_pkg::PH_DIST_CODE;
                end else if (err_r == dfhi_pkg::ERR_NONE) begin
                  err_nxt = dfhi_pkg::ERR_BAD_LENGTH;
                end
              end
            end
            dfhi_pkg::PH_LEN_EXTRA: begin
              if (held_r >= HW'(le_n)) begin
                plen_nxt  = dfhi_pkg::len_base(le_idx) + 9'(buf_r & ext_mask_le);
                buf_nxt   = buf_r >> le_n;
                held_nxt  = held_r - HW'(le_n);
                phase_nxt = dfhi_pkg::PH_DIST_CODE;
              end
            end
            dfhi_pkg::PH_DIST_CODE: begin
              if (held_r >= HW'(5)) begin
                buf_nxt  = buf_r >> 5;
                held_nxt = held_r - HW'(5);
                if (c5 >= 5'd30) begin
                  if (err_r == dfhi_pkg::ERR_NONE) err_nxt = dfhi_pkg::ERR_BAD_DIST;
                  phase_nxt = dfhi_pkg::PH_SYMBOL;
                end else begin
                  pdc_nxt   = c5;
                  phase_nxt = dfhi_pkg::PH_DIST_EXTRA;
                end
              end
            end
            dfhi_pkg::PH_DIST_EXTRA: begin
              if (held_r >= HW'(de_n)) begin
                dist_nxt  = dfhi_pkg::dist_base(de_code) + 16'(buf_r & ext_mask_de);
                buf_nxt   = buf_r >> de_n;
                held_nxt  = held_r - HW'(de_n);
                phase_nxt = dfhi_pkg::PH_COPY;
              end
            end
            dfhi_pkg::PH_COPY: begin
              // read issued at src, byte lands next cycle
            end
            default: phase_nxt = dfhi_pkg::PH_SYMBOL;
          endcase
        end
      end
      dfhi_pkg::ST_REDUCE: begin
        if (dist_r >= 16'(WINDOW_BYTES)) dist_nxt = dist_r - 16'(WINDOW_BYTES);
      end
      dfhi_pkg::ST_COPY: begin
        win_we     = 1'b1;
        win_wdata  = win_rdata;
        obuf_we    = 1'b1;
        obuf_wdata = win_rdata;
        count_nxt  = count_r + CW'(1);
        wp_nxt     = wp_inc;
        if (plen_r > 9'd0) plen_nxt = plen_r - 9'd1;
        if (plen_r <= 9'd1) phase_nxt = dfhi_pkg::PH_SYMBOL;
      end
      dfhi_pkg::ST_EMIT: begin
        if (out_acc && !emit_last) k_nxt = k_r + CW'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    out_valid        = (state_r == dfhi_pkg::ST_EMIT);
    out_byte_valid   = (count_r != '0);
    out_out_byte     = (count_r != '0) ? obuf[k_r[OBW-1:0]] : 8'd0;
    out_last         = emit_last;
    out_end_of_block = done_r;
    out_copy_pending = full_r;
    out_error_code   = err_r;
  end

  // output byte buffer
  always_ff @(posedge clk) begin
    if (obuf_we) begin
      obuf[count_r[OBW-1:0]] <= obuf_wdata;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfhi_pkg::ST_IDLE;
      phase_r     <= dfhi_pkg::PH_SYMBOL;
      buf_r       <= '0;
      held_r      <= '0;
      wp_r        <= '0;
      plen_r      <= '0;
      pdc_r       <= '0;
      dist_r      <= '0;
      done_r      <= 1'b0;
      skip_pend_r <= 1'b1;
      count_r     <= '0;
      k_r         <= '0;
      full_r      <= 1'b0;
      err_r       <= dfhi_pkg::ERR_NONE;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      buf_r       <= buf_nxt;
      held_r      <= held_nxt;
      wp_r        <= wp_nxt;
      plen_r      <= plen_nxt;
      pdc_r       <= pdc_nxt;
      dist_r      <= dist_nxt;
      done_r      <= done_nxt;
      skip_pend_r <= skip_pend_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      full_r      <= full_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

FILE: dv/tb_deflate_fixed_huffman_inflater.sv
// self-checking testbench for deflate_fixed_huffman_inflater
// encodes a fixed-huffman stream, predicts every output beat, checks them in order
// depends on dfhi_pkg and the inflater rtl
`timescale 1ns / 100ps

module tb_deflate_fixed_huffman_inflater;

  localparam int LEN_START [29] = '{
    3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
    35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258};
  localparam int DIST_START [30] = '{
    1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
    257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145, 8193,
    12289, 16385, 24577};

  typedef struct {
    bit [7:0]       data;
    bit             byte_ok;
    bit             last;
    bit             eob;
    bit             pending;
    dfhi_pkg::err_t err;
  } out_beat_t;

  // decoder mirror plus queue of beats still to come
  class inflate_scoreboard;
    bit [2:0]         skip_bits = 3;
    bit [63:0]        bitbuf;
    int unsigned      held;
    bit [7:0]         history [32768];
    bit [14:0]        wpos;
    dfhi_pkg::phase_t phase = dfhi_pkg::PH_SYMBOL;
    int unsigned      pend_len;
    int unsigned      pend_dc;
    int unsigned      copy_dist;
    bit               done;
    bit               skip_pending = 1;
    out_beat_t        beats_due [$];
    int               fails;
    bit               last_pending;
    dfhi_pkg::err_t   last_err;

    function new();
    endfunction

    function int unsigned code_of(int n);
      int unsigned v = 0;
      for (int i = 0; i < n; i++) v = (v << 1) | bitbuf[i];
      return v;
    endfunction

    function void take(int n);
      bitbuf = bitbuf >> n;
      held -= n;
    endfunction

    function void note_input(dfhi_pkg::op_t op, bit [7:0] b);
      bit [7:0]       produced [$];
      int unsigned    c, sym, n, idx;
      bit [7:0]       cb;
      dfhi_pkg::err_t err = dfhi_pkg::ERR_NONE;
      bit             full = 0;
      out_beat_t      r;
      if (op == dfhi_pkg::OP_DATA && !done) begin
        if (held > 24) err = dfhi_pkg::ERR_REFUSED;
        else begin
          bitbuf |= 64'(b) << held;
          held += 8;
          if (skip_pending) begin
            take(skip_bits);
            skip_pending = 0;
          end
        end
      end
      while (!done) begin
        if (produced.size() >= 32) begin
          full = 1;
          break;
        end
        if (phase == dfhi_pkg::PH_SYMBOL) begin
          if (held < 7) break;
          c = code_of(7);
          if (c <= 'h17) begin
            sym = 256 + c; n = 7;
          end else begin
            if (held < 8) break;
            c = code_of(8);
            if (c <= 'hBF) begin
              sym = c - 'h30; n = 8;
            end else if (c <= 'hC7) begin
              sym = 280 + c - 'hC0; n = 8;
            end else begin
              if (held < 9) break;
              sym = 144 + code_of(9) - 'h190; n = 9;
            end
          end
          take(n);
          if (sym < 256) begin
            produced.push_back(8'(sym));
            history[wpos] = 8'(sym);
            wpos++;
          end else if (sym == 256) done = 1;
          else if (sym <= 264) begin
            pend_len = sym - 254; phase = dfhi_pkg::PH_DIST_CODE;
          end else if (sym <= 284) begin
            pend_len = sym - 257; phase = dfhi_pkg::PH_LEN_EXTRA;
          end else if (sym == 285) begin
            pend_len = 258; phase = dfhi_pkg::PH_DIST_CODE;
          end else if (err == dfhi_pkg::ERR_NONE) err = dfhi_pkg::ERR_BAD_LENGTH;
        end else if (phase == dfhi_pkg::PH_LEN_EXTRA) begin
          idx = pend_len;
          if (idx < 8 || idx > 27) idx = 8;
          n = (idx - 4) >> 2;
          if (held < n) break;
          pend_len = LEN_START[idx] + (bitbuf & ((64'd1 << n) - 1));
          take(n);
          phase = dfhi_pkg::PH_DIST_CODE;
        end else if (phase == dfhi_pkg::PH_DIST_CODE) begin
          if (held < 5) break;
          c = code_of(5);
          take(5);
          if (c >= 30) begin
            if (err == dfhi_pkg::ERR_NONE) err = dfhi_pkg::ERR_BAD_DIST;
            phase = dfhi_pkg::PH_SYMBOL;
          end else begin
            pend_dc = c; phase = dfhi_pkg::PH_DIST_EXTRA;
          end
        end else if (phase == dfhi_pkg::PH_DIST_EXTRA) begin
          n = pend_dc < 2 ? 0 : (pend_dc - 2) >> 1;
          if (held < n) break;
          copy_dist = DIST_START[pend_dc] + (bitbuf & ((64'd1 << n) - 1));
          take(n);
          phase = dfhi_pkg::PH_COPY;
        end else if (phase == dfhi_pkg::PH_COPY) begin
          cb = history[15'(wpos - 15'(copy_dist))];
          produced.push_back(cb);
          history[wpos] = cb;
          wpos++;
          if (pend_len > 0) pend_len--;
          if (pend_len == 0) phase = dfhi_pkg::PH_SYMBOL;
        end else phase = dfhi_pkg::PH_SYMBOL;
      end
      n = produced.size() == 0 ? 1 : produced.size();
      for (int k = 0; k < n; k++) begin
        r.data    = produced.size() ? produced[k] : 8'd0;
        r.byte_ok = produced.size() != 0;
        r.last    = (k + 1 == n);
        r.eob     = done;
        r.pending = full;
        r.err     = err;
        beats_due.push_back(r);
      end
      last_pending = full;
      last_err = err;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t w;
      if (beats_due.size() == 0) begin
        $error("unexpected output beat, out_byte %0d", got.data);
        fails++;
        return;
      end
      w = beats_due.pop_front();
      if (got.data != w.data) begin
        $error("out_byte expected %0d got %0d", w.data, got.data); fails++;
      end
      if (got.byte_ok != w.byte_ok) begin
        $error("byte_valid expected %0d got %0d", w.byte_ok, got.byte_ok); fails++;
      end
      if (got.last != w.last) begin
        $error("last expected %0d got %0d", w.last, got.last); fails++;
      end
      if (got.eob != w.eob) begin
        $error("end_of_block expected %0d got %0d", w.eob, got.eob); fails++;
      end
      if (got.pending != w.pending) begin
        $error("copy_pending expected %0d got %0d", w.pending, got.pending); fails++;
      end
      if (got.err != w.err) begin
        $error("error_code expected %0d got %0d", w.err, got.err); fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_operation = 0;
  logic [7:0]  in_data_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_out_byte;
  logic        out_byte_valid, out_last, out_end_of_block, out_copy_pending;
  logic [1:0]  out_error_code;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  deflate_fixed_huffman_inflater dut (.*);

  inflate_scoreboard sb = new();
  int          idle_in = 19, idle_out = 58;
  bit          stream_bits [$];
  bit [7:0]    stream_bytes [$];
  int unsigned window_fill;

  always #5 clk = ~clk;

  // result side: random stalls, check each beat taken
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= idle_out);
      if (out_valid && out_ready)
        sb.check_result('{out_out_byte, out_byte_valid, out_last, out_end_of_block,
                          out_copy_pending, dfhi_pkg::err_t'(out_error_code)});
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic cfg_write(bit [2:0] value);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {dfhi_pkg::REG_SKIP_FIRST_BITS, 2'b00}; cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    sb.skip_bits = value;
    cfg_psel <= 0; cfg_penable <= 0;
  endtask

  // one beat on the input channel, prediction taken at the accepting edge
  task automatic send_item(dfhi_pkg::op_t op, bit [7:0] b);
    int gap = ($urandom_range(99) < idle_in) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_operation <= op; in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, b);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.beats_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic put_lsb(int unsigned v, int n);
    for (int i = 0; i < n; i++) stream_bits.push_back(v[i]);
  endtask

  task automatic put_msb(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic put_sym(int unsigned s);
    if (s < 144) put_msb('h30 + s, 8);
    else if (s < 256) put_msb('h190 + s - 144, 9);
    else if (s < 280) put_msb(s - 256, 7);
    else put_msb('hC0 + s - 280, 8);
  endtask

  task automatic put_literal(int unsigned v);
    put_sym(v);
    window_fill++;
  endtask

  task automatic put_length(int unsigned len);
    int idx = 0;
    while (idx < 28 && LEN_START[idx + 1] <= len) idx++;
    if (idx == 28) put_sym(285);
    else begin
      put_sym(257 + idx);
      if (idx >= 8) put_lsb(len - LEN_START[idx], (idx - 4) >> 2);
    end
  endtask

  // match copy; distance kept within what was already written
  task automatic put_match(int unsigned len, int unsigned d);
    int dc = 0;
    put_length(len);
    while (dc < 29 && DIST_START[dc + 1] <= d) dc++;
    put_msb(dc, 5);
    if (dc >= 2) put_lsb(d - DIST_START[dc], (dc - 2) >> 1);
    window_fill += len;
  endtask

  task automatic put_bad_dist(int unsigned code);
    put_length($urandom_range(3, 258));
    put_msb(code, 5);
  endtask

  initial begin
    bit [2:0]    skip;
    int          idx, stage, r, len, dmax;
    bit          fill_done;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // register extremes, then a continue with nothing pending
    cfg_write(3'd0);
    cfg_write(3'd7);
    send_item(dfhi_pkg::OP_CONTINUE, 8'h00);
    drain();
    skip = 3'($urandom_range(0, 7));
    cfg_write(skip);

    // header bits that the skip drops
    for (int i = 0; i < skip; i++) stream_bits.push_back($urandom_range(1));
    // directed symbols: literal code edges, length/distance edges, bad codes
    put_literal(0); put_literal(143); put_literal(144); put_literal(255);
    put_match(3, 1);
    put_sym(286);
    put_match(10, 2);
    put_match(11, 5);
    put_sym(287);
    put_match(258, 4);
    put_bad_dist(30);
    put_match(257, 9);
    put_bad_dist(31);
    put_literal($urandom_range(255));
    // random symbols, mostly well formed
    for (int i = 0; i < 30; i++) begin
      r = $urandom_range(99);
      if (r < 55) put_literal($urandom_range(255));
      else if (r < 86) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(3, 258) : $urandom_range(3, 20);
        dmax = window_fill > 32768 ? 32768 : window_fill;
        if ($urandom_range(1) == 0 && dmax > 40) dmax = 40;
        put_match(len, $urandom_range(1, dmax));
      end else if (r < 93) put_sym($urandom_range(286, 287));
      else put_bad_dist($urandom_range(30, 31));
    end
    put_sym(256);
    while (stream_bits.size() % 8 != 0) stream_bits.push_back($urandom_range(1));
    for (int i = 0; i < stream_bits.size(); i += 8)
      stream_bytes.push_back({stream_bits[i+7], stream_bits[i+6], stream_bits[i+5],
                              stream_bits[i+4], stream_bits[i+3], stream_bits[i+2],
                              stream_bits[i+1], stream_bits[i]});

    idx = 0; stage = 0; fill_done = 0;
    while (idx < stream_bytes.size() || sb.last_pending || !sb.done) begin
      // idling phases switch at thirds of the stream
      if (stage < 2 && idx >= (stage + 1) * stream_bytes.size() / 3) begin
        drain();
        cfg_write(stage == 0 ? 3'd7 : 3'($urandom_range(0, 7)));
        stage++;
        idle_in  = stage == 1 ? 58 : 0;
        idle_out = stage == 1 ? 19 : 0;
      end
      if (sb.last_pending && idx < stream_bytes.size() &&
          (!fill_done || $urandom_range(3) == 0)) begin
        // early bytes while a copy runs, first time until the buffer refuses
        send_item(dfhi_pkg::OP_DATA, stream_bytes[idx]);
        if (sb.last_err != dfhi_pkg::ERR_REFUSED) idx++;
        else fill_done = 1;
      end else if (sb.last_pending || idx >= stream_bytes.size() ||
                   $urandom_range(9) == 0) begin
        if (!sb.last_pending && idx >= stream_bytes.size() && !sb.done) break;
        send_item(dfhi_pkg::OP_CONTINUE, 8'($urandom_range(255)));
      end else begin
        send_item(dfhi_pkg::OP_DATA, stream_bytes[idx]);
        if (sb.last_err != dfhi_pkg::ERR_REFUSED) idx++;
      end
    end

    // bytes after end of block are ignored
    send_item(dfhi_pkg::OP_DATA, 8'h00);
    send_item(dfhi_pkg::OP_DATA, 8'hFF);
    send_item(dfhi_pkg::OP_CONTINUE, 8'h5A);
    drain();

    if (sb.fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
